/* rtl/ptf_pkg.sv */
package ptf_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_APPEND = 3'd0,
		OP_WRITE  = 3'd1,
		OP_DELETE = 3'd2,
		OP_LOOKUP = 3'd3,
		OP_SETCNT = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_RANGE   = 2'd2,
		ST_NOMATCH = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]  kind;
		logic [31:0] source;
		logic [31:0] dest;
		logic [31:0] port_pair;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		op_t              opcode;
		logic [IDX_W-1:0] entry_index;
		logic [CNT_W-1:0] new_count;
		entry_t           key;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] result_index;
		logic [CNT_W-1:0] entry_count;
	} res_t;

endpackage

/* rtl/ptf_ram.sv */
module ptf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/ptf_engine.sv */
module ptf_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  ptf_pkg::req_t               req,
	output logic                        res_valid,
	input  logic                        res_ready,
	output ptf_pkg::res_t               res,
	output logic                        ram_we,
	output logic [ptf_pkg::IDX_W-1:0]   ram_waddr,
	output ptf_pkg::entry_t             ram_wdata,
	output logic [ptf_pkg::IDX_W-1:0]   ram_raddr,
	input  ptf_pkg::entry_t             ram_rdata
);

	import ptf_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_LK_RD  = 7'b0000010,
		S_LK_CMP = 7'b0000100,
		S_DL_RD  = 7'b0001000,
		S_DL_WR  = 7'b0010000,
		S_CLR    = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] k_q, k_d;
	logic [CNT_W-1:0] tgt_q, tgt_d;
	entry_t           key_q, key_d;
	status_t          st_q, st_d;
	logic [IDX_W-1:0] ridx_q, ridx_d;
	logic [CNT_W-1:0] k1, k2, idx_ext;

	assign k1      = k_q + CNT_W'(1);
	assign k2      = k_q + CNT_W'(2);
	assign idx_ext = CNT_W'(req.entry_index);

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = '{status: st_q, result_index: ridx_q, entry_count: cnt_q};

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		k_d       = k_q;
		tgt_d     = tgt_q;
		key_d     = key_q;
		st_d      = st_q;
		ridx_d    = ridx_q;
		ram_we    = 1'b0;
		ram_waddr = k_q[IDX_W-1:0];
		ram_wdata = req.key;
		ram_raddr = k_q[IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					st_d    = ST_OK;
					ridx_d  = '0;
					key_d   = req.key;
					state_d = S_DONE;
					case (req.opcode)
						OP_APPEND: begin
							if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
								st_d = ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = cnt_q[IDX_W-1:0];
								ridx_d    = cnt_q[IDX_W-1:0];
								cnt_d     = cnt_q + CNT_W'(1);
							end
						end
						OP_WRITE: begin
							if (idx_ext >= cnt_q) begin
								st_d = ST_RANGE;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = req.entry_index;
							end
						end
						OP_DELETE: begin
							k_d = idx_ext;
							if (idx_ext >= cnt_q) begin
								st_d = ST_RANGE;
							end else if (idx_ext + CNT_W'(1) < cnt_q) begin
								state_d = S_DL_RD;
							end else begin
								cnt_d = cnt_q - CNT_W'(1);
							end
						end
						OP_LOOKUP: begin
							k_d = '0;
							if (cnt_q == '0) begin
								st_d = ST_NOMATCH;
							end else begin
								state_d = S_LK_RD;
							end
						end
						OP_SETCNT: begin
							k_d   = '0;
							tgt_d = req.new_count;
							if (req.new_count > CNT_W'(TABLE_DEPTH)) begin
								st_d = ST_RANGE;
							end else if (req.new_count == '0) begin
								cnt_d = '0;
							end else begin
								state_d = S_CLR;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_LK_RD: begin
				state_d = S_LK_CMP;
			end
			S_LK_CMP: begin
				if (ram_rdata == key_q) begin
					ridx_d  = k_q[IDX_W-1:0];
					state_d = S_DONE;
				end else if (k1 >= cnt_q) begin
					st_d    = ST_NOMATCH;
					state_d = S_DONE;
				end else begin
					k_d     = k1;
					state_d = S_LK_RD;
				end
			end
			S_DL_RD: begin
				ram_raddr = k1[IDX_W-1:0];
				state_d   = S_DL_WR;
			end
			S_DL_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				k_d       = k1;
				if (k2 < cnt_q) begin
					state_d = S_DL_RD;
				end else begin
					cnt_d   = cnt_q - CNT_W'(1);
					state_d = S_DONE;
				end
			end
			S_CLR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
				k_d       = k1;
				if (k1 == tgt_q) begin
					cnt_d   = tgt_q;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q    <= k_d;
		tgt_q  <= tgt_d;
		key_q  <= key_d;
		st_q   <= st_d;
		ridx_q <= ridx_d;
	end

endmodule

/* rtl/packet_tuple_filter_table.sv */
// Exact-match five-tuple filter table. Up to TABLE_DEPTH entries (protocol
// type, source and destination address, source and destination port) are
// kept packed at positions 0 to count-1 in a single RAM with one write port
// and one registered read port. Each request transaction carries one
// operation and gives exactly one response transaction with a status, an
// index and the entry count after the operation. Append, write, rejected
// operations and unused opcodes go straight to the response. Lookup reads
// and compares entries in order, up to and including the match (at most the
// count). Delete at index i reads every later entry and writes it back one
// place lower. Set-count writes zero to each entry below new_count, one RAM
// write per cleared entry. All of these steps use the single RAM read and
// write port shared by the sequencer. A finished response waits in an output
// register, so a new request is taken while the previous response is still
// pending; the engine stalls only when a second response would overwrite it.
module packet_tuple_filter_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [2:0]                  opcode,
	input  logic [ptf_pkg::IDX_W-1:0]   entry_index,
	input  logic [ptf_pkg::CNT_W-1:0]   new_count,
	input  logic [7:0]                  proto_type,
	input  logic [31:0]                 src_addr,
	input  logic [31:0]                 dst_addr,
	input  logic [15:0]                 src_port,
	input  logic [15:0]                 dst_port,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [1:0]                  status,
	output logic [ptf_pkg::IDX_W-1:0]   result_index,
	output logic [ptf_pkg::CNT_W-1:0]   entry_count
);

	import ptf_pkg::*;

	req_t             req;
	res_t             res;
	logic             res_valid;
	logic             res_ready;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_rdata;
	logic [ENTRY_W-1:0] ram_rdata_raw;
	logic             out_valid_q;
	res_t             out_q;

	// The request fields are gathered into one struct; the two ports are
	// stored together as one word, source port in the upper half.
	assign req.opcode          = op_t'(opcode);
	assign req.entry_index     = entry_index;
	assign req.new_count       = new_count;
	assign req.key.kind        = proto_type;
	assign req.key.source      = src_addr;
	assign req.key.dest        = dst_addr;
	assign req.key.port_pair   = {src_port, dst_port};

	ptf_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// Entry storage. Contents are not reset: only entries below the count are
	// ever read, and each of them was appended, written or cleared first.
	ptf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = entry_t'(ram_rdata_raw);

	// Output register: the engine hands over a result whenever the register is
	// empty or its transaction completes in this cycle.
	assign res_ready = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp_valid    = out_valid_q;
	assign status       = out_q.status;
	assign result_index = out_q.result_index;
	assign entry_count  = out_q.entry_count;

	// The count reported never exceeds the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (entry_count <= CNT_W'(TABLE_DEPTH)))
		else $error("entry count above table depth");

	// A full refusal only happens with every slot in use.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status == ST_FULL)) |-> (entry_count == CNT_W'(TABLE_DEPTH)))
		else $error("table full reported below depth");

	// Refused requests and failed lookups report index zero.
	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && ((status == ST_RANGE) || (status == ST_NOMATCH)))
		|-> (result_index == '0))
		else $error("nonzero index on failed operation");

	// The engine works on one request at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while engine busy");

endmodule

/* tb/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ptf_pkg::*;

	// Opcodes 5 to 7 are not used by the block. It answers them with an ok status
	// and leaves the table unchanged.
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

	// These are the fields of one request transaction, as the testbench sees them.
	// The opcode is a plain vector, so the spare opcodes can be carried as well.
	typedef struct {
		logic [2:0]       opcode;
		logic [IDX_W-1:0] entry_index;
		logic [CNT_W-1:0] new_count;
		entry_t           key;
	} filter_cmd_t;

	// This is a shadow copy of the filter table. It keeps the entries, the fill
	// count and the responses still owed by the block, oldest first.
	class filter_table_shadow;
		entry_t      slots[TABLE_DEPTH];
		int unsigned fill;
		res_t        owed[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned op_count[8];
		int unsigned lookup_hits;
		int unsigned full_refusals;
		int unsigned range_refusals;

		function void note_mismatch(string what, res_t want, res_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch (%s): expected status %0d index %0d count %0d, got status %0d index %0d count %0d",
					what, want.status, want.result_index, want.entry_count,
					got.status, got.result_index, got.entry_count);
		endfunction

		// Apply one accepted request to the table and queue the response it owes.
		function void apply_request(filter_cmd_t c);
			res_t r;
			bit   found;
			r.status       = ST_OK;
			r.result_index = '0;
			found          = 1'b0;
			op_count[c.opcode]++;
			case (c.opcode)
				OP_APPEND: begin
					if (fill >= TABLE_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						slots[fill]    = c.key;
						r.result_index = IDX_W'(fill);
						fill++;
					end
				end
				OP_WRITE: begin
					if (c.entry_index >= fill)
						r.status = ST_RANGE;
					else
						slots[c.entry_index] = c.key;
				end
				OP_DELETE: begin
					if (c.entry_index >= fill) begin
						r.status = ST_RANGE;
					end else begin
						for (int k = c.entry_index; k + 1 < fill; k++)
							slots[k] = slots[k + 1];
						fill--;
					end
				end
				OP_LOOKUP: begin
					r.status = ST_NOMATCH;
					for (int k = 0; k < fill; k++) begin
						if (!found && slots[k] == c.key) begin
							found          = 1'b1;
							r.status       = ST_OK;
							r.result_index = IDX_W'(k);
						end
					end
					if (found)
						lookup_hits++;
				end
				OP_SETCNT: begin
					if (c.new_count > TABLE_DEPTH) begin
						r.status = ST_RANGE;
					end else begin
						for (int k = 0; k < c.new_count; k++)
							slots[k] = '0;
						fill = c.new_count;
					end
				end
				default: begin
				end
			endcase
			if (r.status == ST_FULL)
				full_refusals++;
			if (r.status == ST_RANGE)
				range_refusals++;
			r.entry_count = CNT_W'(fill);
			owed.push_back(r);
		endfunction

		// Compare one accepted response with the oldest response still owed.
		function void check_response(res_t got);
			res_t want;
			if (owed.size() == 0) begin
				want = '0;
				note_mismatch("response with none owed", want, got);
			end else begin
				want = owed.pop_front();
				checked++;
				if (got.status != want.status || got.result_index != want.result_index ||
						got.entry_count != want.entry_count)
					note_mismatch("field", want, got);
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	logic [2:0]       opcode = '0;
	logic [IDX_W-1:0] entry_index = '0;
	logic [CNT_W-1:0] new_count = '0;
	logic [7:0]       proto_type = '0;
	logic [31:0]      src_addr = '0;
	logic [31:0]      dst_addr = '0;
	logic [15:0]      src_port = '0;
	logic [15:0]      dst_port = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	logic [1:0]       status;
	logic [IDX_W-1:0] result_index;
	logic [CNT_W-1:0] entry_count;

	// These are the idle rates in percent for the sender and the receiver. The
	// main sequence changes them from one phase to the next.
	int unsigned send_idle_pct = 11;
	int unsigned recv_idle_pct = 82;
	int unsigned sent = 0;

	filter_table_shadow shadow = new();

	packet_tuple_filter_table u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.opcode       (opcode),
		.entry_index  (entry_index),
		.new_count    (new_count),
		.proto_type   (proto_type),
		.src_addr     (src_addr),
		.dst_addr     (dst_addr),
		.src_port     (src_port),
		.dst_port     (dst_port),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.status       (status),
		.result_index (result_index),
		.entry_count  (entry_count)
	);

	always #2 clk = ~clk;

	// The receiver side. Outputs are sampled right at the rising edge, before
	// any register of the block has updated, so the values seen are the ones
	// the handshake used. Ready is then drawn again for the next cycle, with
	// one nonblocking update per edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				shadow.check_response('{status_t'(status), result_index, entry_count});
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic filter_cmd_t make_cmd(logic [2:0] op, int unsigned idx,
			int unsigned cnt, entry_t key);
		filter_cmd_t c;
		c.opcode      = op;
		c.entry_index = IDX_W'(idx);
		c.new_count   = CNT_W'(cnt);
		c.key         = key;
		return c;
	endfunction

	// Keys are either fully random, or drawn from a tiny space in which every
	// field is 0 or 1. The tiny space makes duplicate entries common, so the
	// lookup has to pick the lowest matching index.
	function automatic entry_t random_key();
		entry_t k;
		if ($urandom_range(99) < 40) begin
			k.kind      = 8'($urandom);
			k.source    = $urandom;
			k.dest      = $urandom;
			k.port_pair = $urandom;
		end else begin
			k.kind      = 8'($urandom_range(1));
			k.source    = 32'($urandom_range(1));
			k.dest      = 32'($urandom_range(1));
			k.port_pair = {16'($urandom_range(1)), 16'($urandom_range(1))};
		end
		return k;
	endfunction

	// Send one request transaction. An idle gap may come first, and valid is
	// lowered only during such a gap. Back-to-back requests keep valid high,
	// so valid is never dropped and raised again at the same edge. The shadow
	// table is updated at the edge where the request is accepted.
	task automatic send_command(input filter_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid   <= 1'b1;
		opcode      <= c.opcode;
		entry_index <= c.entry_index;
		new_count   <= c.new_count;
		proto_type  <= c.key.kind;
		src_addr    <= c.key.source;
		dst_addr    <= c.key.dest;
		src_port    <= c.key.port_pair[31:16];
		dst_port    <= c.key.port_pair[15:0];
		do
			@(posedge clk);
		while (!req_ready);
		shadow.apply_request(c);
		sent++;
	endtask

	// Build one random operation from the current state of the shadow table.
	// Write and delete mostly hit an index in use. Lookup mostly uses the key of
	// an entry in use, and sometimes the same key with one bit flipped, so that
	// near misses are tried as well.
	task automatic random_command();
		filter_cmd_t c;
		int unsigned pick;
		int unsigned fill;
		int unsigned flip;
		fill          = shadow.fill;
		pick          = $urandom_range(99);
		c.entry_index = IDX_W'($urandom);
		c.new_count   = CNT_W'($urandom);
		c.key         = random_key();
		if (pick < 27) begin
			c.opcode = OP_APPEND;
		end else if (pick < 60) begin
			c.opcode = (pick < 42) ? OP_WRITE : OP_DELETE;
			if (fill > 0 && $urandom_range(99) < 85)
				c.entry_index = IDX_W'($urandom_range(fill - 1));
		end else if (pick < 90) begin
			c.opcode = OP_LOOKUP;
			if (fill > 0 && $urandom_range(99) < 65) begin
				c.key = shadow.slots[$urandom_range(fill - 1)];
				if ($urandom_range(99) < 20) begin
					flip  = $urandom_range($bits(entry_t) - 1);
					c.key = c.key ^ (entry_t'(1) << flip);
				end
			end
		end else if (pick < 96) begin
			c.opcode = OP_SETCNT;
			if ($urandom_range(99) < 80)
				c.new_count = CNT_W'($urandom_range(TABLE_DEPTH));
			else
				c.new_count = CNT_W'($urandom_range((1 << CNT_W) - 1, TABLE_DEPTH + 1));
		end else begin
			c.opcode = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
		end
		send_command(c);
	endtask

	initial begin
		entry_t ones;
		entry_t zero;
		entry_t probe;
		int unsigned drain;
		ones  = '1;
		zero  = '0;
		probe = random_key();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed part. It starts with refusals on the empty table and with
		// the spare opcodes.
		send_command(make_cmd(OP_LOOKUP, 0, 0, zero));
		send_command(make_cmd(OP_WRITE, 0, 0, ones));
		send_command(make_cmd(OP_DELETE, 0, 0, ones));
		send_command(make_cmd(OP_SETCNT, 0, TABLE_DEPTH + 1, zero));
		send_command(make_cmd(OP_SETCNT, 15, (1 << CNT_W) - 1, ones));
		for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
			send_command(make_cmd(3'(op), 15, 31, ones));
		// Next comes a full, cleared table. An append must be refused, and the
		// all-zero key must match at index 0.
		send_command(make_cmd(OP_SETCNT, 0, TABLE_DEPTH, zero));
		send_command(make_cmd(OP_APPEND, 0, 0, ones));
		send_command(make_cmd(OP_LOOKUP, 0, 0, zero));
		// The last slot and the lowest-index rule for duplicate keys come next.
		send_command(make_cmd(OP_WRITE, TABLE_DEPTH - 1, 0, ones));
		send_command(make_cmd(OP_LOOKUP, 0, 0, ones));
		send_command(make_cmd(OP_WRITE, 0, 0, ones));
		send_command(make_cmd(OP_LOOKUP, 0, 0, ones));
		// This part deletes at the end of the table, then tries an index equal to
		// the count. After that, an append fills the slot again and a delete at
		// the front shifts every later entry down.
		send_command(make_cmd(OP_DELETE, TABLE_DEPTH - 1, 0, zero));
		send_command(make_cmd(OP_DELETE, TABLE_DEPTH - 1, 0, zero));
		send_command(make_cmd(OP_WRITE, TABLE_DEPTH - 1, 0, zero));
		send_command(make_cmd(OP_APPEND, 0, 0, ones));
		send_command(make_cmd(OP_DELETE, 0, 0, zero));
		send_command(make_cmd(OP_LOOKUP, 0, 0, ones));
		// The table is emptied, refilled with one entry, and then probed with a
		// key that is off by one bit.
		send_command(make_cmd(OP_SETCNT, 0, 0, zero));
		send_command(make_cmd(OP_APPEND, 0, 0, probe));
		probe.kind = probe.kind ^ 8'h01;
		send_command(make_cmd(OP_LOOKUP, 0, 0, probe));

		// The random part runs in three phases. In the first, the receiver is the
		// slow side. In the second, the sender is. In the third, neither side
		// idles.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 82 : 0;
			recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 11 : 0;
			repeat (410) random_command();
		end
		req_valid <= 1'b0;

		// Wait for every owed response. After that, a quiet stretch longer than
		// the slowest scan catches any stray response.
		drain = 0;
		while (shadow.owed.size() != 0 && drain < 100000) begin
			@(posedge clk);
			drain++;
		end
		repeat (80) @(posedge clk);

		$display("covered %0d requests: append %0d (full %0d), write %0d, delete %0d, lookup %0d (hit %0d)",
			sent, shadow.op_count[OP_APPEND], shadow.full_refusals, shadow.op_count[OP_WRITE],
			shadow.op_count[OP_DELETE], shadow.op_count[OP_LOOKUP], shadow.lookup_hits);
		$display("set-count %0d, spare opcodes %0d, range refusals %0d, responses checked %0d, mismatches %0d, still owed %0d",
			shadow.op_count[OP_SETCNT],
			shadow.op_count[OP_SPARE_FIRST] + shadow.op_count[3'd6] + shadow.op_count[OP_SPARE_LAST],
			shadow.range_refusals, shadow.checked, shadow.mismatches, shadow.owed.size());
		if (shadow.mismatches == 0 && shadow.owed.size() == 0)
			$display("packet_tuple_filter_table regression: pass");
		else
			$display("packet_tuple_filter_table regression: fail");
		$finish;
	end

	// This is the watchdog. The slowest item is a full scan, plus long waits on
	// the stalled side. Even at that pace, about 1300 items finish well before
	// the watchdog fires.
	initial begin
		#4000000;
		$display("packet_tuple_filter_table regression: fail");
		$finish;
	end

endmodule
